@@ rtl/ffha_pkg.sv @@
`default_nettype none
package ffha_pkg;

  localparam int HEAP_BYTES   = 16777216;
  localparam int MAX_SEGMENTS = 64;
  localparam int HEADER_BYTES = 16;
  localparam int MIN_PAYLOAD  = 16;

  localparam int OFF_W  = $clog2(HEAP_BYTES);
  localparam int SIZE_W = OFF_W + 1;
  localparam int IDX_W  = $clog2(MAX_SEGMENTS);
  localparam int CNT_W  = IDX_W + 1;

  typedef logic [OFF_W-1:0]  off_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef struct packed {
    off_t  start;
    size_t size;
    logic  free;
  } seg_t;

  localparam int SEG_W = $bits(seg_t);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NULL    = 2'd1,
    ST_DOUBLE  = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_RD,
    S_CHK,
    S_NXT_RD,
    S_NXT_CHK,
    S_SH_RD,
    S_SH_WR,
    S_WA,
    S_WB,
    S_RESP
  } state_t;

endpackage
`default_nettype wire

@@ rtl/first_fit_heap_allocator.sv @@
`default_nettype none
// First-fit heap allocator. The segment table lives in one synchronous RAM
// (one read and one write port, registered read) and is walked one entry at
// a time, each entry read (S_RD) and then checked (S_CHK). When a split
// inserts or a merge removes table entries, the entries behind them are
// moved one at a time, each read (S_SH_RD) and then written (S_SH_WR).
// After reset the block writes the initial segment (S_INIT) before it accepts
// its first item. A result sits in an output register until taken, while the
// block goes back to accept the next item.
module first_fit_heap_allocator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        cmd,
  input  wire logic [24:0] request_bytes,
  input  wire logic [31:0] release_addr,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      granted_addr,
  output logic [1:0]       status
);

  localparam int IW = ffha_pkg::IDX_W;
  localparam int CW = ffha_pkg::CNT_W;
  localparam int SW = ffha_pkg::SIZE_W;
  localparam int OW = ffha_pkg::OFF_W;

  ffha_pkg::state_t state, state_next;

  logic [31:0]      base;
  ffha_pkg::cnt_t   count;
  ffha_pkg::cnt_t   idx;
  logic             op_free;
  ffha_pkg::size_t  a_req;
  logic [31:0]      off_tgt;
  ffha_pkg::seg_t   cur, prev;
  logic             has_next;
  ffha_pkg::cnt_t   sh_src, sh_cnt;
  logic             sh_up;
  logic [1:0]       sh_gap;
  logic [IW-1:0]    wa_addr, wb_addr;
  ffha_pkg::seg_t   wa_data, wb_data;
  logic             wb_en;
  logic [31:0]      res_addr;
  ffha_pkg::status_t res_status;

  logic                    ram_we;
  logic [IW-1:0]           ram_waddr, ram_raddr;
  logic [ffha_pkg::SEG_W-1:0] ram_wdata, ram_rdata;

  ffha_ram #(.WIDTH(ffha_pkg::SEG_W), .DEPTH(ffha_pkg::MAX_SEGMENTS)) u_seg_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ffha_pkg::seg_t rd;
  logic [31:0]    base_al;
  logic [SW:0]    rnd;
  logic           fit, split, is_last, app_ok, match, nf, pf;
  logic [SW:0]    ns;
  logic [SW+1:0]  app_end;
  logic           in_xfer;
  ffha_pkg::cnt_t idx_inc, cnt_max;

  assign rd      = ffha_pkg::seg_t'(ram_rdata);
  assign base_al = {base[31:2], 2'b00};
  assign rnd     = ({1'b0, request_bytes} + (SW+1)'(3)) & ~(SW+1)'(3);
  assign in_xfer = in_valid && in_ready;
  assign idx_inc = idx + CW'(1);
  assign cnt_max = CW'(ffha_pkg::MAX_SEGMENTS);

  assign fit     = rd.free && (rd.size >= a_req);
  assign split   = ({1'b0, rd.size} >= {1'b0, a_req}
                    + (SW+1)'(ffha_pkg::HEADER_BYTES + ffha_pkg::MIN_PAYLOAD))
                   && (count < cnt_max);
  assign is_last = (idx_inc == count);
  assign ns      = (SW+1)'(rd.start) + (SW+1)'(ffha_pkg::HEADER_BYTES) + (SW+1)'(rd.size);
  assign app_end = (SW+2)'(ns) + (SW+2)'(ffha_pkg::HEADER_BYTES) + (SW+2)'(a_req);
  assign app_ok  = (count < cnt_max) && (app_end <= (SW+2)'(ffha_pkg::HEAP_BYTES));
  assign match   = (off_tgt[31:OW] == '0) && (off_tgt[OW-1:0] == rd.start);
  assign nf      = has_next && rd.free;
  assign pf      = (idx != '0) && prev.free;

  assign in_ready = (state == ffha_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffha_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = wa_addr;
    ram_wdata  = wa_data;
    ram_raddr  = idx[IW-1:0];
    case (state)
      ffha_pkg::S_INIT: begin
        ram_we     = 1'b1;
        ram_waddr  = '0;
        ram_wdata  = {ffha_pkg::off_t'(0),
                      SW'(ffha_pkg::HEAP_BYTES - ffha_pkg::HEADER_BYTES), 1'b1};
        state_next = ffha_pkg::S_IDLE;
      end
      ffha_pkg::S_IDLE: begin
        if (in_xfer) begin
          if ((cmd == ffha_pkg::CMD_ALLOC && request_bytes == '0) ||
              (cmd == ffha_pkg::CMD_FREE && release_addr == '0)) begin
            state_next = ffha_pkg::S_RESP;
          end else begin
            state_next = ffha_pkg::S_RD;
          end
        end
      end
      ffha_pkg::S_RD: begin
        state_next = ffha_pkg::S_CHK;
      end
      ffha_pkg::S_CHK: begin
        if (!op_free) begin
          if (fit) begin
            if (split && (count != idx_inc)) begin
              state_next = ffha_pkg::S_SH_RD;
            end else begin
              state_next = ffha_pkg::S_WA;
            end
          end else if (is_last) begin
            state_next = app_ok ? ffha_pkg::S_WA : ffha_pkg::S_RESP;
          end else begin
            state_next = ffha_pkg::S_RD;
          end
        end else begin
          if (match) begin
            state_next = rd.free ? ffha_pkg::S_RESP : ffha_pkg::S_NXT_RD;
          end else begin
            state_next = is_last ? ffha_pkg::S_RESP : ffha_pkg::S_RD;
          end
        end
      end
      ffha_pkg::S_NXT_RD: begin
        ram_raddr  = idx_inc[IW-1:0];
        state_next = ffha_pkg::S_NXT_CHK;
      end
      ffha_pkg::S_NXT_CHK: begin
        if ((nf && (count != idx + CW'(2))) || (!nf && pf && !is_last)) begin
          state_next = ffha_pkg::S_SH_RD;
        end else begin
          state_next = ffha_pkg::S_WA;
        end
      end
      ffha_pkg::S_SH_RD: begin
        ram_raddr  = sh_src[IW-1:0];
        state_next = ffha_pkg::S_SH_WR;
      end
      ffha_pkg::S_SH_WR: begin
        ram_we     = 1'b1;
        ram_wdata  = ram_rdata;
        ram_waddr  = sh_up ? IW'(sh_src + CW'(1)) : IW'(sh_src - CW'(sh_gap));
        state_next = (sh_cnt == CW'(1)) ? ffha_pkg::S_WA : ffha_pkg::S_SH_RD;
      end
      ffha_pkg::S_WA: begin
        ram_we     = 1'b1;
        state_next = wb_en ? ffha_pkg::S_WB : ffha_pkg::S_RESP;
      end
      ffha_pkg::S_WB: begin
        ram_we     = 1'b1;
        ram_waddr  = wb_addr;
        ram_wdata  = wb_data;
        state_next = ffha_pkg::S_RESP;
      end
      ffha_pkg::S_RESP: begin
        if (!out_valid || out_ready) begin
          state_next = ffha_pkg::S_IDLE;
        end
      end
      default: state_next = ffha_pkg::S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base      <= '0;
      count     <= CW'(1);
      out_valid <= 1'b0;
      wb_en     <= 1'b0;
    end else begin
      if (cfg_we) begin
        base <= cfg_wdata;
      end
      if (out_valid && out_ready && state != ffha_pkg::S_RESP) begin
        out_valid <= 1'b0;
      end
      case (state)
        ffha_pkg::S_IDLE: begin
          if (in_xfer) begin
            op_free    <= (cmd == ffha_pkg::CMD_FREE);
            idx        <= '0;
            wb_en      <= 1'b0;
            prev       <= '0;
            res_addr   <= '0;
            res_status <= ffha_pkg::ST_NULL;
            // A rounded request past the field width can never be granted.
            a_req      <= rnd[SW] ? '1 :
                          (rnd < (SW+1)'(ffha_pkg::MIN_PAYLOAD)) ?
                          SW'(ffha_pkg::MIN_PAYLOAD) : rnd[SW-1:0];
            off_tgt    <= release_addr - base_al - 32'(ffha_pkg::HEADER_BYTES);
          end
        end
        ffha_pkg::S_CHK: begin
          if (!op_free) begin
            if (fit) begin
              res_addr   <= base_al + 32'(rd.start) + 32'(ffha_pkg::HEADER_BYTES);
              res_status <= ffha_pkg::ST_OK;
              if (split) begin
                // Make room at idx+1 by moving the tail of the table up one entry.
                wa_addr <= idx_inc[IW-1:0];
                wa_data <= {rd.start + OW'(ffha_pkg::HEADER_BYTES) + OW'(a_req),
                            rd.size - a_req - SW'(ffha_pkg::HEADER_BYTES), 1'b1};
                wb_en   <= 1'b1;
                wb_addr <= idx[IW-1:0];
                wb_data <= {rd.start, a_req, 1'b0};
                sh_up   <= 1'b1;
                sh_src  <= count - CW'(1);
                sh_cnt  <= count - idx_inc;
                count   <= count + CW'(1);
              end else begin
                wa_addr <= idx[IW-1:0];
                wa_data <= {rd.start, rd.size, 1'b0};
              end
            end else if (is_last) begin
              if (app_ok) begin
                wa_addr    <= count[IW-1:0];
                wa_data    <= {OW'(ns), a_req, 1'b0};
                count      <= count + CW'(1);
                res_addr   <= base_al + 32'(ns) + 32'(ffha_pkg::HEADER_BYTES);
                res_status <= ffha_pkg::ST_OK;
              end
            end else begin
              idx <= idx_inc;
            end
          end else begin
            if (match) begin
              cur        <= rd;
              has_next   <= !is_last;
              res_status <= rd.free ? ffha_pkg::ST_DOUBLE : ffha_pkg::ST_OK;
            end else begin
              prev <= rd;
              idx  <= idx_inc;
              if (is_last) begin
                res_status <= ffha_pkg::ST_UNKNOWN;
              end
            end
          end
        end
        ffha_pkg::S_NXT_CHK: begin
          sh_up <= 1'b0;
          if (nf && pf) begin
            wa_addr <= IW'(idx - CW'(1));
            wa_data <= {prev.start, prev.size + cur.size + rd.size
                        + SW'(2 * ffha_pkg::HEADER_BYTES), 1'b1};
            sh_gap  <= 2'd2;
            sh_src  <= idx + CW'(2);
            sh_cnt  <= count - idx - CW'(2);
            count   <= count - CW'(2);
          end else if (nf) begin
            wa_addr <= idx[IW-1:0];
            wa_data <= {cur.start, cur.size + rd.size + SW'(ffha_pkg::HEADER_BYTES), 1'b1};
            sh_gap  <= 2'd1;
            sh_src  <= idx + CW'(2);
            sh_cnt  <= count - idx - CW'(2);
            count   <= count - CW'(1);
          end else if (pf) begin
            wa_addr <= IW'(idx - CW'(1));
            wa_data <= {prev.start, prev.size + cur.size + SW'(ffha_pkg::HEADER_BYTES), 1'b1};
            sh_gap  <= 2'd1;
            sh_src  <= idx_inc;
            sh_cnt  <= count - idx_inc;
            count   <= count - CW'(1);
          end else begin
            wa_addr <= idx[IW-1:0];
            wa_data <= {cur.start, cur.size, 1'b1};
          end
        end
        ffha_pkg::S_SH_WR: begin
          sh_cnt <= sh_cnt - CW'(1);
          sh_src <= sh_up ? sh_src - CW'(1) : sh_src + CW'(1);
        end
        ffha_pkg::S_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            granted_addr <= res_addr;
            status       <= res_status;
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count != '0) && (count <= cnt_max))
    else $error("segment count out of range");

  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ffha_pkg::S_RESP) && out_valid && !out_ready |=> state == ffha_pkg::S_RESP)
    else $error("result dropped while output register full");

  a_shift_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ffha_pkg::S_SH_RD || state == ffha_pkg::S_SH_WR) |-> sh_cnt != '0)
    else $error("table move with no entries left");
`endif

endmodule
`default_nettype wire

@@ rtl/ffha_ram.sv @@
`default_nettype none
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
